@@ sv/tga_rle_pkg.sv @@
package tga_rle_pkg;

  // Header layout (byte offsets, little endian)
  localparam logic [4:0] HDR_ID_LEN   = 5'd0;
  localparam logic [4:0] HDR_CMAP     = 5'd1;
  localparam logic [4:0] HDR_IMG_TYPE = 5'd2;
  localparam logic [4:0] HDR_W_LO     = 5'd12;
  localparam logic [4:0] HDR_W_HI     = 5'd13;
  localparam logic [4:0] HDR_H_LO     = 5'd14;
  localparam logic [4:0] HDR_H_HI     = 5'd15;
  localparam logic [4:0] HDR_BPP      = 5'd16;
  localparam logic [4:0] HDR_LAST     = 5'd17;

  localparam logic [7:0] IMG_TYPE_RAW = 8'd2;
  localparam logic [7:0] IMG_TYPE_RLE = 8'd10;
  localparam logic [7:0] BPP_24       = 8'd24;
  localparam logic [7:0] BPP_32       = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] PKT_LEN_MASK = 8'h7f;
  localparam int         PKT_RUN_BIT  = 7;
  localparam logic [7:0] RUN_MAX      = 8'd128;

  typedef enum logic [1:0] {
    KIND_SIZE = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] first_pixel;
    logic [7:0]  repeat_count;
    logic        image_done;
  } res_t;

  // Header unit -> core
  typedef struct packed {
    logic        last;    // current byte completes the header
    logic        ok;      // supported format
    logic        rle;
    logic        alpha;
    logic [7:0]  id_len;
    logic [15:0] width;
    logic [15:0] height;
  } hdr_info_t;

endpackage

@@ sv/tga_rle_if.sv @@
interface tga_rle_in_if;
  import tga_rle_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface tga_rle_out_if;
  import tga_rle_pkg::*;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [31:0] first_pixel;
  logic [7:0]  repeat_count;
  logic        image_done;

  modport source (output valid, output kind, output image_width, output image_height,
                  output red, output green, output blue, output alpha,
                  output first_pixel, output repeat_count, output image_done,
                  input ready);
  modport sink   (input valid, input kind, input image_width, input image_height,
                  input red, input green, input blue, input alpha,
                  input first_pixel, input repeat_count, input image_done,
                  output ready);
endinterface

@@ sv/tga_rle_hdr.sv @@
module tga_rle_hdr (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr,
  input  logic                   sof,
  input  logic [7:0]             data_byte,
  output tga_rle_pkg::hdr_info_t info
);
  import tga_rle_pkg::*;

  logic [4:0]  pos_r, pos_nxt, pos_eff;
  logic [7:0]  id_len_r, cmap_r, itype_r, bpp_r;
  logic [15:0] width_r, height_r;

  assign pos_eff = sof ? 5'd0 : pos_r;
  assign pos_nxt = wr ? pos_eff + 5'd1 : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 5'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Only the fields we use are kept; valid once all earlier bytes are in.
  always_ff @(posedge clk) begin
    if (wr) begin
      case (pos_eff)
        HDR_ID_LEN:   id_len_r        <= data_byte;
        HDR_CMAP:     cmap_r          <= data_byte;
        HDR_IMG_TYPE: itype_r         <= data_byte;
        HDR_W_LO:     width_r[7:0]    <= data_byte;
        HDR_W_HI:     width_r[15:8]   <= data_byte;
        HDR_H_LO:     height_r[7:0]   <= data_byte;
        HDR_H_HI:     height_r[15:8]  <= data_byte;
        HDR_BPP:      bpp_r           <= data_byte;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    info.last   = (pos_eff == HDR_LAST);
    info.ok     = ((itype_r == IMG_TYPE_RAW) || (itype_r == IMG_TYPE_RLE)) &&
                  (cmap_r == 8'd0) && ((bpp_r == BPP_24) || (bpp_r == BPP_32));
    info.rle    = (itype_r == IMG_TYPE_RLE);
    info.alpha  = (bpp_r == BPP_32);
    info.id_len = id_len_r;
    info.width  = width_r;
    info.height = height_r;
  end

endmodule

@@ sv/tga_rle_core.sv @@
module tga_rle_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   acc,
  input  logic [7:0]             data_byte,
  input  logic                   sof,
  input  tga_rle_pkg::hdr_info_t hdr,
  output logic                   hdr_wr,
  output logic                   res_vld,
  output tga_rle_pkg::res_t      res
);
  import tga_rle_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_IDSKIP,
    PH_PIXELS,
    PH_IDLE
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [7:0]  id_left_r, id_left_nxt;
  logic        rle_r, rle_nxt;
  logic        alpha_r, alpha_nxt;
  logic [31:0] left_r, left_nxt;       // pixels still to emit
  logic [31:0] emitted_r, emitted_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;
  logic        pkt_run_r, pkt_run_nxt;
  logic [1:0]  cbi_r, cbi_nxt;
  logic [7:0]  blue_r, blue_nxt, green_r, green_nxt, red_r, red_nxt;

  logic [31:0] area;
  logic        empty;
  logic [7:0]  cnt_raw, cnt;
  logic [7:0]  px_red, px_alpha;

  assign phase_eff = sof ? PH_HEADER : phase_r;
  assign hdr_wr    = acc && (phase_eff == PH_HEADER);
  assign area      = 32'(hdr.width) * 32'(hdr.height);
  assign empty     = (hdr.width == 16'd0) || (hdr.height == 16'd0);

  always_comb begin
    phase_nxt    = phase_r;
    id_left_nxt  = id_left_r;
    rle_nxt      = rle_r;
    alpha_nxt    = alpha_r;
    left_nxt     = left_r;
    emitted_nxt  = emitted_r;
    pkt_left_nxt = pkt_left_r;
    pkt_run_nxt  = pkt_run_r;
    cbi_nxt      = cbi_r;
    blue_nxt     = blue_r;
    green_nxt    = green_r;
    red_nxt      = red_r;
    res          = '0;
    res_vld      = 1'b0;
    cnt_raw      = 8'd1;
    cnt          = 8'd1;
    px_red       = red_r;
    px_alpha     = data_byte;

    if (acc) begin
      case (phase_eff)
        PH_HEADER: begin
          phase_nxt = PH_HEADER;
          if (hdr.last) begin
            res_vld = 1'b1;
            if (!hdr.ok) begin
              phase_nxt = PH_IDLE;
              res.kind  = KIND_ERR;
            end else begin
              rle_nxt          = hdr.rle;
              alpha_nxt        = hdr.alpha;
              left_nxt         = area;
              emitted_nxt      = 32'd0;
              pkt_left_nxt     = 8'd0;
              pkt_run_nxt      = 1'b0;
              cbi_nxt          = 2'd0;
              id_left_nxt      = hdr.id_len;
              if (hdr.id_len != 8'd0) begin
                phase_nxt = PH_IDSKIP;
              end else if (empty) begin
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_PIXELS;
              end
              res.kind         = KIND_SIZE;
              res.image_width  = hdr.width;
              res.image_height = hdr.height;
            end
          end
        end
        PH_IDSKIP: begin
          id_left_nxt = id_left_r - 8'd1;
          if (id_left_nxt == 8'd0) begin
            phase_nxt = (left_r == 32'd0) ? PH_IDLE : PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          if (rle_r && (pkt_left_r == 8'd0)) begin
            // packet header
            pkt_left_nxt = (data_byte & PKT_LEN_MASK) + 8'd1;
            pkt_run_nxt  = data_byte[PKT_RUN_BIT];
            cbi_nxt      = 2'd0;
          end else if (cbi_r == 2'd0) begin
            blue_nxt = data_byte;
            cbi_nxt  = 2'd1;
          end else if (cbi_r == 2'd1) begin
            green_nxt = data_byte;
            cbi_nxt   = 2'd2;
          end else if ((cbi_r == 2'd2) && alpha_r) begin
            red_nxt = data_byte;
            cbi_nxt = 2'd3;
          end else begin
            // last colour byte: emit
            if (cbi_r == 2'd2) begin
              px_red   = data_byte;
              px_alpha = ALPHA_OPAQUE;
            end
            cbi_nxt = 2'd0;
            if (rle_r) begin
              if (pkt_run_r) begin
                cnt_raw      = pkt_left_r;
                pkt_left_nxt = 8'd0;
              end else begin
                pkt_left_nxt = pkt_left_r - 8'd1;
              end
            end
            cnt = (left_r < 32'(cnt_raw)) ? left_r[7:0] : cnt_raw;
            left_nxt    = left_r - 32'(cnt);
            emitted_nxt = emitted_r + 32'(cnt);
            if (left_nxt == 32'd0) begin
              phase_nxt = PH_IDLE;
            end
            res_vld          = 1'b1;
            res.kind         = KIND_RUN;
            res.red          = px_red;
            res.green        = green_r;
            res.blue         = blue_r;
            res.alpha        = px_alpha;
            res.first_pixel  = emitted_r;
            res.repeat_count = cnt;
            res.image_done   = (left_nxt == 32'd0);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      id_left_r  <= 8'd0;
      rle_r      <= 1'b0;
      alpha_r    <= 1'b0;
      left_r     <= 32'd0;
      emitted_r  <= 32'd0;
      pkt_left_r <= 8'd0;
      pkt_run_r  <= 1'b0;
      cbi_r      <= 2'd0;
    end else begin
      phase_r    <= phase_nxt;
      id_left_r  <= id_left_nxt;
      rle_r      <= rle_nxt;
      alpha_r    <= alpha_nxt;
      left_r     <= left_nxt;
      emitted_r  <= emitted_nxt;
      pkt_left_r <= pkt_left_nxt;
      pkt_run_r  <= pkt_run_nxt;
      cbi_r      <= cbi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blue_r  <= blue_nxt;
    green_r <= green_nxt;
    red_r   <= red_nxt;
  end

endmodule

@@ sv/tga_rle_obuf.sv @@
module tga_rle_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tga_rle_pkg::res_t push_data,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tga_rle_pkg::res_t out_data
);
  import tga_rle_pkg::*;

  // Output register plus one skid entry.
  logic vld_r, vld_nxt, skid_vld_r, skid_vld_nxt;
  res_t data_r, data_nxt, skid_r, skid_nxt;
  logic pop;

  assign pop       = vld_r && out_ready;
  assign in_ready  = !skid_vld_r;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_comb begin
    vld_nxt      = vld_r;
    skid_vld_nxt = skid_vld_r;
    data_nxt     = data_r;
    skid_nxt     = skid_r;
    if (pop) begin
      if (skid_vld_r) begin
        data_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        vld_nxt  = push;
        data_nxt = push_data;
      end
    end else if (push) begin
      if (!vld_r) begin
        vld_nxt  = 1'b1;
        data_nxt = push_data;
      end else begin
        skid_vld_nxt = 1'b1;
        skid_nxt     = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    skid_r <= skid_nxt;
  end

endmodule

@@ sv/tga_rle_pixel_decoder.sv @@
// Truecolor TGA decoder, one file byte per request on in_ch. The 18-byte
// header is parsed first; on its last byte a size report (kind 0) or an
// unsupported-format error (kind 2) comes out. Supported: image type 2
// (raw) or 10 (run-length), no colormap, 24 or 32 bits per pixel. After
// the ID field is skipped, every raw pixel, literal pixel or run comes out
// as one kind 1 request: RGBA colour (alpha 255 for 24-bit data), the
// file-order index of its first pixel and a repeat count clipped to the
// image; image_done marks the one holding the last pixel. Index i maps to
// row height-1-i/width, column i mod width. A byte with start_of_file set
// restarts parsing and counts as header byte 0; bytes after the image or
// after an error are dropped until then. Rate: one byte per clock while
// in_ch.ready is high. Each byte is decoded combinationally between the
// input and the result register, or the skid entry while the output
// register is stalled. The result path has an output register and one
// skid entry; in_ch.ready drops only while both hold undelivered results.
// No clearing pass after reset.
module tga_rle_pixel_decoder (
  input logic          clk,
  input logic          rst_n,
  tga_rle_in_if.sink   in_ch,
  tga_rle_out_if.source out_ch
);
  import tga_rle_pkg::*;

  logic      acc;
  logic      hdr_wr;
  hdr_info_t hdr;
  logic      res_vld;
  res_t      res;
  res_t      out_data;
  logic      buf_ready;

  assign in_ch.ready = buf_ready;
  assign acc         = in_ch.valid && buf_ready;

  // Header capture and format check
  tga_rle_hdr u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (hdr_wr),
    .sof       (in_ch.start_of_file),
    .data_byte (in_ch.data_byte),
    .info      (hdr)
  );

  // Phase control, ID skip, packet and colour assembly
  tga_rle_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_ch.data_byte),
    .sof       (in_ch.start_of_file),
    .hdr       (hdr),
    .hdr_wr    (hdr_wr),
    .res_vld   (res_vld),
    .res       (res)
  );

  // Result register + skid
  tga_rle_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .in_ready  (buf_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.kind         = out_data.kind;
  assign out_ch.image_width  = out_data.image_width;
  assign out_ch.image_height = out_data.image_height;
  assign out_ch.red          = out_data.red;
  assign out_ch.green        = out_data.green;
  assign out_ch.blue         = out_data.blue;
  assign out_ch.alpha        = out_data.alpha;
  assign out_ch.first_pixel  = out_data.first_pixel;
  assign out_ch.repeat_count = out_data.repeat_count;
  assign out_ch.image_done   = out_data.image_done;

endmodule

@@ sv/tga_rle_chk.sv @@
module tga_rle_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_repeat_count,
  input logic       out_image_done
);
  import tga_rle_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_RUN) |->
      (out_repeat_count != 8'd0) && (out_repeat_count <= RUN_MAX))
    else $error("run repeat count out of range");

  a_nonrun_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_RUN) |->
      !out_image_done && (out_repeat_count == 8'd0))
    else $error("run fields set on a non-run result");

endmodule

bind tga_rle_pixel_decoder tga_rle_chk u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_repeat_count (out_ch.repeat_count),
  .out_image_done   (out_ch.image_done)
);
